### hdl/edc_pkg.sv
// Package for the case-insensitive edit distance unit.
// Holds sizing constants, item and result word types and shared helper functions.
// No dependencies.
`timescale 1ns / 1ps

package edc_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int COST_BITS = 16;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int COST_AW = LEN_W;

	localparam logic [31:0] COST_MAX = 32'((64'd1 << COST_BITS) - 64'd1);

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_TEXT = 2'd2;
	localparam logic [1:0] KIND_FINISH = 2'd3;

	typedef logic [COST_BITS-1:0] cost_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
	} edc_item_t;

	typedef struct packed {
		logic [15:0] distance;
		logic overflow;
	} edc_result_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic cost_t sat_cost(input logic [31:0] v);
		if (v > COST_MAX) begin
			return COST_MAX[COST_BITS-1:0];
		end
		return v[COST_BITS-1:0];
	endfunction

	function automatic logic [15:0] sat_distance(input cost_t c);
		logic [31:0] v;
		v = 32'(c);
		if (v > 32'h0000_FFFF) begin
			return 16'hFFFF;
		end
		return v[15:0];
	endfunction

endpackage

### hdl/edit_distance_ci_unit.sv
// Case-insensitive edit distance unit: sequencer, pattern and cost RAMs, one shared cell.
// Clear and append words never raise busy. A text word holds busy while it updates the
// L cost cells (L = stored pattern length), one cost cell per cycle through the shared cell
// and the cost RAM port; a finish word raises done via ST_FIN and the done register, or in
// the next cycle if L is zero. The receiver cannot stall; done is a one-cycle strobe. Reset
// clears control state only; the RAMs are not initialized, and every cell is written before use.
`timescale 1ns / 1ps

module edit_distance_ci_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	input edc_pkg::edc_item_t item,
	output logic busy,
	output logic done,
	output edc_pkg::edc_result_t result
);
	import edc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0] state_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0] tcount_q;
	logic ovf_q;
	logic [LEN_W-1:0] j_q;
	cost_t left_q;
	cost_t diag_q;
	logic [7:0] txt_q;
	logic done_q;
	edc_result_t result_q;

	logic accept;
	logic [15:0] tcount_next;
	logic [LEN_W-1:0] len_inc;

	logic pat_we;
	logic [PAT_AW-1:0] pat_waddr;
	logic [PAT_AW-1:0] pat_raddr;
	logic [7:0] pat_rdata;

	logic cost_we;
	logic [COST_AW-1:0] cost_waddr;
	cost_t cost_wdata;
	logic [COST_AW-1:0] cost_raddr;
	cost_t cost_rdata;

	cost_t cell_best;
	logic [LEN_W-1:0] rd_idx;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign tcount_next = (tcount_q == 16'hFFFF) ? tcount_q : tcount_q + 16'd1;
	assign len_inc = len_q + LEN_W'(1);

	edc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PATTERN)
	) u_pat_ram (
		.clk(clk),
		.we(pat_we),
		.waddr(pat_waddr),
		.wdata(item.symbol),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	edc_ram #(
		.WIDTH(COST_BITS),
		.DEPTH(MAX_PATTERN + 1)
	) u_cost_ram (
		.clk(clk),
		.we(cost_we),
		.waddr(cost_waddr),
		.wdata(cost_wdata),
		.raddr(cost_raddr),
		.rdata(cost_rdata)
	);

	edc_cell u_cell (
		.up(cost_rdata),
		.left(left_q),
		.diag(diag_q),
		.pat(pat_rdata),
		.txt(txt_q),
		.best(cell_best)
	);

	// Reads run one cell ahead of the write, so cell j+1 is fetched while cell j is written.
	always_comb begin
		pat_we = 1'b0;
		pat_waddr = len_q[PAT_AW-1:0];
		cost_we = 1'b0;
		cost_waddr = len_inc[COST_AW-1:0];
		cost_wdata = sat_cost(32'(len_inc));
		rd_idx = LEN_W'(1);
		cost_raddr = len_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.kind == KIND_APPEND && tcount_q == 16'd0
						&& len_q != LEN_W'(MAX_PATTERN)) begin
					pat_we = 1'b1;
					cost_we = 1'b1;
				end
				if (accept && item.kind == KIND_TEXT) begin
					cost_raddr = rd_idx;
				end
			end
			ST_RUN: begin
				cost_we = 1'b1;
				cost_waddr = j_q;
				cost_wdata = cell_best;
				rd_idx = j_q + LEN_W'(1);
				cost_raddr = rd_idx;
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
		pat_raddr = PAT_AW'(rd_idx - LEN_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			tcount_q <= '0;
			ovf_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.kind)
							KIND_CLEAR: begin
								len_q <= '0;
								tcount_q <= '0;
								ovf_q <= 1'b0;
							end
							KIND_APPEND: begin
								if (tcount_q == 16'd0) begin
									if (len_q == LEN_W'(MAX_PATTERN)) begin
										ovf_q <= 1'b1;
									end else begin
										len_q <= len_inc;
									end
								end
							end
							KIND_TEXT: begin
								tcount_q <= tcount_next;
								if (len_q != '0) begin
									state_q <= ST_RUN;
								end
							end
							KIND_FINISH: begin
								if (len_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_FIN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					if (j_q == len_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; cell 0 of the row always equals the saturated text count.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.kind == KIND_TEXT) begin
					j_q <= LEN_W'(1);
					txt_q <= item.symbol;
					diag_q <= sat_cost(32'(tcount_q));
					left_q <= sat_cost(32'(tcount_next));
				end
				if (accept && item.kind == KIND_FINISH && len_q == '0) begin
					result_q.distance <= sat_distance(sat_cost(32'(tcount_q)));
					result_q.overflow <= ovf_q;
				end
			end
			ST_RUN: begin
				left_q <= cell_best;
				diag_q <= cost_rdata;
				j_q <= j_q + LEN_W'(1);
			end
			ST_FIN: begin
				result_q.distance <= sat_distance(cost_rdata);
				result_q.overflow <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = result_q;

endmodule

### hdl/edc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the pattern store and the cost row. No dependencies.
`timescale 1ns / 1ps

module edc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/edc_cell.sv
// Shared cost cell update: one Levenshtein recurrence step per use.
// Depends on edc_pkg for the cost type and the case fold.
`timescale 1ns / 1ps

module edc_cell (
	input edc_pkg::cost_t up,
	input edc_pkg::cost_t left,
	input edc_pkg::cost_t diag,
	input logic [7:0] pat,
	input logic [7:0] txt,
	output edc_pkg::cost_t best
);
	import edc_pkg::*;

	function automatic cost_t sat_inc(input cost_t v);
		if (32'(v) >= COST_MAX) begin
			return v;
		end
		return v + cost_t'(1);
	endfunction

	cost_t del_c;
	cost_t ins_c;
	cost_t sub_c;
	cost_t min_di;

	always_comb begin
		del_c = sat_inc(up);
		ins_c = sat_inc(left);
		sub_c = (fold(pat) != fold(txt)) ? sat_inc(diag) : diag;
		min_di = (del_c < ins_c) ? del_c : ins_c;
		best = (sub_c < min_di) ? sub_c : min_di;
	end

endmodule

### dv/edit_distance_ci_check.sv
// Checker for the edit distance unit: watches the word and result channels, keeps its own
// model of the cost row and compares every distance word against it.
// Depends on edc_pkg for the word types and sizing constants.
`timescale 1ns / 1ps

module edit_distance_ci_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input edc_pkg::edc_item_t item,
	input logic busy,
	input logic done,
	input edc_pkg::edc_result_t result,
	input logic drain,
	output int errors,
	output int waiting,
	output int distances_checked,
	output int overflow_seen,
	output int saturated_seen
);
	import edc_pkg::*;

	localparam int COST_CAP = int'(COST_MAX);

	logic [7:0] pat_mem [MAX_PATTERN];
	int cost_cells [MAX_PATTERN + 1];
	int pat_len;
	int txt_cnt;
	bit drop_flag;
	bit drained;

	edc_result_t distance_q [$];
	edc_result_t want;
	edc_result_t fresh;
	bit emits;

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic int clip_cost(input int v);
		return (v > COST_CAP) ? COST_CAP : v;
	endfunction

	function automatic int bump_cost(input int v);
		return (v >= COST_CAP) ? COST_CAP : v + 1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// Advances the model by one accepted word; only a finish word yields a distance.
	task automatic model_word(input edc_item_t w, output bit gives, output edc_result_t r);
		logic [7:0] t;
		int diag;
		int up;
		int del_c;
		int ins_c;
		int sub_c;
		int best_c;
		int d;
		gives = 1'b0;
		r = '0;
		case (w.kind)
			KIND_CLEAR: begin
				pat_len = 0;
				txt_cnt = 0;
				drop_flag = 1'b0;
				cost_cells[0] = 0;
			end
			KIND_APPEND: begin
				if (txt_cnt == 0) begin
					if (pat_len >= MAX_PATTERN) begin
						drop_flag = 1'b1;
					end else begin
						pat_mem[pat_len] = w.symbol;
						pat_len++;
						cost_cells[pat_len] = clip_cost(pat_len);
					end
				end
			end
			KIND_TEXT: begin
				t = lower_ascii(w.symbol);
				if (txt_cnt < 16'hFFFF) begin
					txt_cnt++;
				end
				diag = cost_cells[0];
				cost_cells[0] = clip_cost(txt_cnt);
				for (int j = 1; j <= pat_len; j++) begin
					up = cost_cells[j];
					del_c = bump_cost(up);
					ins_c = bump_cost(cost_cells[j - 1]);
					sub_c = (lower_ascii(pat_mem[j - 1]) != t) ? bump_cost(diag) : diag;
					best_c = (del_c < ins_c) ? del_c : ins_c;
					if (sub_c < best_c) begin
						best_c = sub_c;
					end
					cost_cells[j] = best_c;
					diag = up;
				end
			end
			KIND_FINISH: begin
				d = cost_cells[pat_len];
				r.distance = (d > 16'hFFFF) ? 16'hFFFF : d[15:0];
				r.overflow = drop_flag;
				gives = 1'b1;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pat_mem[i]) pat_mem[i] = '0;
			foreach (cost_cells[i]) cost_cells[i] = 0;
			pat_len = 0;
			txt_cnt = 0;
			drop_flag = 1'b0;
			drained = 1'b0;
			distance_q.delete();
			errors = 0;
			waiting = 0;
			distances_checked = 0;
			overflow_seen = 0;
			saturated_seen = 0;
		end else begin
			// A result always trails its finish word, so it is matched before new words.
			if (done) begin
				if (distance_q.size() == 0) begin
					report_mismatch($sformatf("distance word %0d/%0b with nothing expected",
						result.distance, result.overflow));
				end else begin
					want = distance_q.pop_front();
					if (result.distance !== want.distance) begin
						report_mismatch($sformatf("distance %0d, expected %0d",
							result.distance, want.distance));
					end
					if (result.overflow !== want.overflow) begin
						report_mismatch($sformatf("overflow %0b, expected %0b",
							result.overflow, want.overflow));
					end
					distances_checked++;
					if (want.overflow) begin
						overflow_seen++;
					end
					if (want.distance == 16'hFFFF) begin
						saturated_seen++;
					end
				end
			end
			if (start && !busy) begin
				model_word(item, emits, fresh);
				if (emits) begin
					distance_q.push_back(fresh);
				end
			end
			if (drain && !drained) begin
				drained = 1'b1;
				if (distance_q.size() != 0) begin
					report_mismatch($sformatf("%0d distance words never arrived",
						distance_q.size()));
				end
			end
			waiting = distance_q.size();
		end
	end

endmodule

### dv/edit_distance_ci_unit_tb.sv
// Testbench top for edit_distance_ci_unit: drives directed, overflow and random words
// and gives the verdict from the checker's error count.
// Depends on edc_pkg, the unit and edit_distance_ci_check.
`timescale 1ns / 1ps

module edit_distance_ci_unit_tb;
	import edc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	edc_item_t item = '0;
	logic busy;
	logic done;
	edc_result_t result;
	logic drain = 1'b0;

	int errors;
	int waiting;
	int distances_checked;
	int overflow_seen;
	int saturated_seen;

	bit steady;
	int words_sent;
	int base;

	always #5 clk = ~clk;

	edit_distance_ci_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	edit_distance_ci_check distance_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.drain(drain),
		.errors(errors),
		.waiting(waiting),
		.distances_checked(distances_checked),
		.overflow_seen(overflow_seen),
		.saturated_seen(saturated_seen)
	);

	// Offers one word and returns once the unit has taken it.
	task automatic send_word(input logic [1:0] k, input logic [7:0] s);
		if (!steady && $urandom_range(99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{kind: k, symbol: s};
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	// Mostly a few letters in both cases so that matches are common.
	function automatic logic [7:0] pick_symbol();
		int r;
		logic [7:0] edges [8];
		edges = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
		r = $urandom_range(99);
		if (r < 50) begin
			return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(3));
		end
		if (r < 65) begin
			return edges[$urandom_range(7)];
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic int pick_pattern_len();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(8);
		if (r < 90) return $urandom_range(9, 32);
		if (r < 97) return $urandom_range(33, MAX_PATTERN - 1);
		return $urandom_range(MAX_PATTERN, MAX_PATTERN + 6);
	endfunction

	// One comparison: clear (not always, unless fresh), pattern, text with finishes along the way,
	// a closing finish. Stray words and late appends are mixed in as noise.
	task automatic run_session(input int plen, input int tlen, input bit fresh);
		if (fresh || $urandom_range(9) != 0) begin
			send_word(KIND_CLEAR, 8'($urandom_range(255)));
		end
		for (int i = 0; i < plen; i++) begin
			if ($urandom_range(99) < 4) begin
				send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
			end
			send_word(KIND_APPEND, pick_symbol());
		end
		for (int i = 0; i < tlen; i++) begin
			send_word(KIND_TEXT, pick_symbol());
			if ($urandom_range(99) < 20) begin
				send_word(KIND_FINISH, 8'($urandom_range(255)));
			end
			if ($urandom_range(99) < 5) begin
				send_word(KIND_APPEND, pick_symbol());
			end
			if ($urandom_range(99) < 4) begin
				send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
			end
		end
		send_word(KIND_FINISH, 8'($urandom_range(255)));
	endtask

	initial begin
		steady = 1'b0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty strings, fold boundaries, late append, finish then more text.
		send_word(KIND_CLEAR, 8'h00);
		send_word(KIND_FINISH, 8'h00);
		send_word(KIND_APPEND, 8'h41);
		send_word(KIND_APPEND, 8'hFF);
		send_word(KIND_APPEND, 8'h5A);
		send_word(KIND_FINISH, 8'hFF);
		send_word(KIND_TEXT, 8'h61);
		send_word(KIND_TEXT, 8'h00);
		send_word(KIND_TEXT, 8'h7A);
		send_word(KIND_FINISH, 8'h00);
		send_word(KIND_APPEND, 8'h42);
		send_word(KIND_TEXT, 8'h80);
		send_word(KIND_FINISH, 8'h00);
		send_word(KIND_CLEAR, 8'hFF);
		send_word(KIND_TEXT, 8'h5B);
		send_word(KIND_TEXT, 8'h40);
		send_word(KIND_FINISH, 8'h00);
		send_word(KIND_CLEAR, 8'h00);
		send_word(KIND_APPEND, 8'h60);
		send_word(KIND_APPEND, 8'h7B);
		send_word(KIND_TEXT, 8'h60);
		send_word(KIND_TEXT, 8'h7B);
		send_word(KIND_FINISH, 8'h00);
		send_word(KIND_TEXT, 8'h20);
		send_word(KIND_FINISH, 8'h00);

		// A full pattern with extra appends that must be dropped.
		run_session(MAX_PATTERN + 2, 3, 1'b1);

		base = words_sent;
		while (words_sent - base < 1550) begin
			steady = (words_sent - base >= 700) && (words_sent - base < 1000);
			run_session(pick_pattern_len(),
				($urandom_range(99) < 80) ? $urandom_range(10) : $urandom_range(11, 40),
				1'b0);
		end
		steady = 1'b0;
		start <= 1'b0;

		for (int k = 0; k < 2000 && waiting != 0; k++) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		drain <= 1'b1;
		repeat (2) @(posedge clk);

		$display("covered %0d words over directed, full-pattern and random sessions",
			words_sent);
		$display("%0d distances compared, %0d with a dropped pattern byte, %0d saturated",
			distances_checked, overflow_seen, saturated_seen);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d distance words outstanding", waiting);
		$display("status: fail");
		$finish;
	end

endmodule
